// File: design/ppmsd_pkg.sv
// ----------------------------------------------------------------------------
// ppmsd_pkg
// Types, codes and helpers shared by the P6 stream decoder.
// ----------------------------------------------------------------------------
package ppmsd_pkg;

    localparam int MAX_DIM          = 4096;
    localparam int MAX_SAMPLE_VALUE = 65535;

    localparam int DIM_W   = 13;
    localparam int MAXV_W  = 16;
    localparam int TOK_W   = 17;
    localparam int BYTES_W = 26;
    localparam int ERR_W   = 3;
    localparam int KIND_W  = 2;
    localparam int DIV_W   = 16;

    localparam logic [TOK_W-1:0] TOK_CAP = {TOK_W{1'b1}};

    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_6     = 8'h36;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [MAXV_W-1:0] FULL_SCALE = 16'd255;

    typedef enum logic [KIND_W-1:0] {
        KIND_HEADER = 2'd0,
        KIND_SAMPLE = 2'd1,
        KIND_ERROR  = 2'd2
    } kind_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_BAD_MAGIC = 3'd0,
        ERR_NO_DIGITS = 3'd1,
        ERR_ZERO      = 3'd2,
        ERR_TOO_LARGE = 3'd3,
        ERR_EARLY_END = 3'd4
    } err_t;

    typedef enum logic [1:0] {
        MAG_NONE     = 2'd0,
        MAG_SAW_P    = 2'd1,
        MAG_SAW_P6   = 2'd2,
        MAG_MISMATCH = 2'd3
    } magic_t;

    typedef enum logic [6:0] {
        PH_MAGIC  = 7'b0000001,
        PH_WIDTH  = 7'b0000010,
        PH_HEIGHT = 7'b0000100,
        PH_MAXVAL = 7'b0001000,
        PH_DATA   = 7'b0010000,
        PH_DONE   = 7'b0100000,
        PH_ERROR  = 7'b1000000
    } phase_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_DIV  = 2'b10
    } seq_t;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

endpackage

// File: design/ppm_p6_stream_decoder.sv
// ----------------------------------------------------------------------------
// ppm_p6_stream_decoder
// Parses a binary PPM (P6) byte stream: header tokens, then rescaled samples.
// ----------------------------------------------------------------------------
// Timing: a result reaches the output register in the cycle after its word is
//   taken, or once the divider is done for a rescaled sample.
// Flow: header bytes and samples with max value 255 bypass the divider; other
//   samples hold off new bytes while the shared restoring divider retires one
//   quotient bit per cycle over 16 steps; input also waits while the output word is unread.
// Reset: synchronous, active low; clears the parser, the divider sequencer and the output valid flag.
module ppm_p6_stream_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,   // stream_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [7:0] sample, [20:8] image_width, [33:21] image_height,
                                   // [49:34] max_value, [52:50] error_code, [55:53] zero
    output logic [ppmsd_pkg::KIND_W-1:0] m_tuser,  // [1:0] kind
    output logic        m_tlast    // last
);
    import ppmsd_pkg::*;

    // parser state
    phase_t                 phase_reg, phase_next;
    logic                   in_comment_reg, in_comment_next;
    logic                   in_token_reg, in_token_next;
    logic [TOK_W-1:0]       tok_val_reg, tok_val_next;
    logic                   tok_digits_reg, tok_digits_next;
    logic                   tok_neg_reg, tok_neg_next;
    logic                   tok_stop_reg, tok_stop_next;
    logic                   tok_ovf_reg, tok_ovf_next;
    magic_t                 magic_reg, magic_next;
    logic [DIM_W-1:0]       width_reg, width_next;
    logic [DIM_W-1:0]       height_reg, height_next;
    logic [MAXV_W-1:0]      maxval_reg, maxval_next;
    logic [BYTES_W-1:0]     bytes_left_reg, bytes_left_next;

    // divider sequencer
    seq_t                   state_reg, state_next;
    logic [3:0]             div_cnt_reg, div_cnt_next;
    logic [DIV_W-1:0]       dvd_reg, dvd_next;
    logic [DIV_W-1:0]       rem_reg, rem_next;
    logic [DIV_W-1:0]       quo_reg, quo_next;
    logic                   div_last_reg, div_last_next;

    // output register
    logic                   out_valid_reg, out_valid_next;
    kind_t                  out_kind_reg, out_kind_next;
    logic [7:0]             out_sample_reg, out_sample_next;
    logic [DIM_W-1:0]       out_width_reg, out_width_next;
    logic [DIM_W-1:0]       out_height_reg, out_height_next;
    logic [MAXV_W-1:0]      out_maxval_reg, out_maxval_next;
    err_t                   out_err_reg, out_err_next;
    logic                   out_last_reg, out_last_next;

    logic                   accept;
    logic [7:0]             c;
    logic                   c_digit;
    logic [20:0]            tok_mul;
    logic [TOK_W-1:0]       chk_val;
    logic [TOK_W-1:0]       chk_bound;
    logic                   chk_ok;
    err_t                   chk_err;
    logic [2*DIM_W-1:0]     pix_count;
    logic [BYTES_W+1:0]     byte_count;
    logic [DIV_W:0]         trial;
    logic                   trial_ge;
    logic [DIV_W:0]         trial_diff;
    logic [DIV_W-1:0]       quo_done;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE) && (!out_valid_reg || m_tready);
    assign c        = s_tdata;
    assign c_digit  = (c >= CH_0) && (c <= CH_9);
    assign tok_mul  = ({4'd0, tok_val_reg} << 3) + ({4'd0, tok_val_reg} << 1)
                    + {13'd0, c - CH_0};

    // token check
    assign chk_val   = tok_neg_reg ? '0 : tok_val_reg;
    assign chk_bound = (phase_reg == PH_MAXVAL) ? TOK_W'(MAX_SAMPLE_VALUE) : TOK_W'(MAX_DIM);
    always_comb begin
        chk_ok  = 1'b0;
        chk_err = ERR_BAD_MAGIC;
        if (phase_reg == PH_MAGIC) begin
            chk_ok = (magic_reg == MAG_SAW_P6);
        end else if (!tok_digits_reg) begin
            chk_err = ERR_NO_DIGITS;
        end else if (!tok_neg_reg && (tok_ovf_reg || (chk_val > chk_bound))) begin
            chk_err = ERR_TOO_LARGE;
        end else if ((phase_reg == PH_MAXVAL) &&
                     ((width_reg == '0) || (height_reg == '0) || (chk_val[15:0] == '0))) begin
            chk_err = ERR_ZERO;
        end else begin
            chk_ok = 1'b1;
        end
    end

    assign pix_count  = width_reg * height_reg;
    assign byte_count = {2'd0, pix_count} + {1'b0, pix_count, 1'b0};

    // one restoring division step
    assign trial      = {rem_reg, dvd_reg[DIV_W-1]};
    assign trial_ge   = trial >= {1'b0, maxval_reg};
    assign trial_diff = trial - {1'b0, maxval_reg};
    assign quo_done   = {quo_reg[DIV_W-2:0], trial_ge};

    always_comb begin
        phase_next      = phase_reg;
        in_comment_next = in_comment_reg;
        in_token_next   = in_token_reg;
        tok_val_next    = tok_val_reg;
        tok_digits_next = tok_digits_reg;
        tok_neg_next    = tok_neg_reg;
        tok_stop_next   = tok_stop_reg;
        tok_ovf_next    = tok_ovf_reg;
        magic_next      = magic_reg;
        width_next      = width_reg;
        height_next     = height_reg;
        maxval_next     = maxval_reg;
        bytes_left_next = bytes_left_reg;
        state_next      = state_reg;
        div_cnt_next    = div_cnt_reg;
        dvd_next        = dvd_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        div_last_next   = div_last_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_kind_next   = out_kind_reg;
        out_sample_next = out_sample_reg;
        out_width_next  = out_width_reg;
        out_height_next = out_height_reg;
        out_maxval_next = out_maxval_reg;
        out_err_next    = out_err_reg;
        out_last_next   = out_last_reg;

        if (state_reg == ST_DIV) begin
            dvd_next     = {dvd_reg[DIV_W-2:0], 1'b0};
            rem_next     = trial_ge ? trial_diff[DIV_W-1:0] : trial[DIV_W-1:0];
            quo_next     = quo_done;
            div_cnt_next = div_cnt_reg + 4'd1;
            if (div_cnt_reg == 4'd15) begin
                state_next      = ST_IDLE;
                out_valid_next  = 1'b1;
                out_kind_next   = KIND_SAMPLE;
                out_sample_next = (|quo_done[DIV_W-1:8]) ? 8'hFF : quo_done[7:0];
                out_width_next  = '0;
                out_height_next = '0;
                out_maxval_next = '0;
                out_err_next    = ERR_BAD_MAGIC;
                out_last_next   = div_last_reg;
            end
        end

        if (accept) begin
            // clear result fields; each branch below fills what it reports
            out_sample_next = '0;
            out_width_next  = '0;
            out_height_next = '0;
            out_maxval_next = '0;
            out_err_next    = ERR_BAD_MAGIC;
            out_last_next   = 1'b0;
            if (s_tlast) begin
                if ((phase_reg == PH_MAGIC) || (phase_reg == PH_WIDTH) ||
                    (phase_reg == PH_HEIGHT) || (phase_reg == PH_MAXVAL)) begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_ERROR;
                    out_err_next   = (in_token_reg && !chk_ok) ? chk_err : ERR_EARLY_END;
                    out_last_next  = 1'b1;
                end else if (phase_reg == PH_DATA) begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_ERROR;
                    out_err_next   = ERR_EARLY_END;
                    out_last_next  = 1'b1;
                end
                phase_next      = PH_MAGIC;
                in_comment_next = 1'b0;
                in_token_next   = 1'b0;
                tok_val_next    = '0;
                tok_digits_next = 1'b0;
                tok_neg_next    = 1'b0;
                tok_stop_next   = 1'b0;
                tok_ovf_next    = 1'b0;
                magic_next      = MAG_NONE;
                width_next      = '0;
                height_next     = '0;
                maxval_next     = '0;
                bytes_left_next = '0;
            end else if (phase_reg == PH_DATA) begin
                bytes_left_next = bytes_left_reg - BYTES_W'(1);
                if (bytes_left_reg == BYTES_W'(1)) begin
                    phase_next = PH_DONE;
                end
                if ((maxval_reg == FULL_SCALE) || (maxval_reg == '0)) begin
                    out_valid_next  = 1'b1;
                    out_kind_next   = KIND_SAMPLE;
                    out_sample_next = c;
                    out_last_next   = (bytes_left_reg == BYTES_W'(1));
                end else begin
                    // sample*255 = (sample << 8) - sample
                    state_next    = ST_DIV;
                    div_cnt_next  = '0;
                    dvd_next      = {c, 8'd0} - {8'd0, c};
                    rem_next      = '0;
                    quo_next      = '0;
                    div_last_next = (bytes_left_reg == BYTES_W'(1));
                end
            end else if ((phase_reg == PH_DONE) || (phase_reg == PH_ERROR)) begin
                // drop trailing bytes
            end else if (in_comment_reg) begin
                if (c == CH_LF) begin
                    in_comment_next = 1'b0;
                end
            end else if (!in_token_reg && is_blank(c)) begin
                // skip whitespace between tokens
            end else if (!in_token_reg && (c == CH_HASH)) begin
                in_comment_next = 1'b1;
            end else if (!is_blank(c)) begin
                in_token_next = 1'b1;
                if (phase_reg == PH_MAGIC) begin
                    if (!in_token_reg) begin
                        magic_next = (c == CH_P) ? MAG_SAW_P : MAG_MISMATCH;
                    end else begin
                        magic_next = ((magic_reg == MAG_SAW_P) && (c == CH_6)) ?
                                     MAG_SAW_P6 : MAG_MISMATCH;
                    end
                end else if (!tok_stop_reg) begin
                    priority if (c_digit) begin
                        tok_digits_next = 1'b1;
                        if (tok_mul > {4'd0, TOK_CAP}) begin
                            tok_val_next = TOK_CAP;
                            tok_ovf_next = 1'b1;
                        end else begin
                            tok_val_next = tok_mul[TOK_W-1:0];
                        end
                    end else if (!in_token_reg && (c == CH_PLUS)) begin
                        // optional plus sign
                    end else if (!in_token_reg && (c == CH_MINUS)) begin
                        tok_neg_next = 1'b1;
                    end else begin
                        tok_stop_next = 1'b1;
                    end
                end
            end else begin
                // blank closes the open token
                in_token_next   = 1'b0;
                tok_val_next    = '0;
                tok_digits_next = 1'b0;
                tok_neg_next    = 1'b0;
                tok_stop_next   = 1'b0;
                tok_ovf_next    = 1'b0;
                magic_next      = MAG_NONE;
                if (phase_reg == PH_WIDTH) begin
                    width_next = chk_val[DIM_W-1:0];
                end
                if (phase_reg == PH_HEIGHT) begin
                    height_next = chk_val[DIM_W-1:0];
                end
                if (phase_reg == PH_MAXVAL) begin
                    maxval_next = chk_val[MAXV_W-1:0];
                end
                if (!chk_ok) begin
                    phase_next     = PH_ERROR;
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_ERROR;
                    out_err_next   = chk_err;
                    out_last_next  = 1'b1;
                end else if (phase_reg == PH_MAXVAL) begin
                    bytes_left_next = byte_count[BYTES_W-1:0];
                    phase_next      = (byte_count[BYTES_W-1:0] == '0) ? PH_DONE : PH_DATA;
                    out_valid_next  = 1'b1;
                    out_kind_next   = KIND_HEADER;
                    out_width_next  = width_reg;
                    out_height_next = height_reg;
                    out_maxval_next = chk_val[MAXV_W-1:0];
                end else if (phase_reg == PH_MAGIC) begin
                    phase_next = PH_WIDTH;
                end else if (phase_reg == PH_WIDTH) begin
                    phase_next = PH_HEIGHT;
                end else begin
                    phase_next = PH_MAXVAL;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_MAGIC;
            in_comment_reg <= 1'b0;
            in_token_reg   <= 1'b0;
            tok_val_reg    <= '0;
            tok_digits_reg <= 1'b0;
            tok_neg_reg    <= 1'b0;
            tok_stop_reg   <= 1'b0;
            tok_ovf_reg    <= 1'b0;
            magic_reg      <= MAG_NONE;
            width_reg      <= '0;
            height_reg     <= '0;
            maxval_reg     <= '0;
            bytes_left_reg <= '0;
            state_reg      <= ST_IDLE;
            div_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            phase_reg      <= phase_next;
            in_comment_reg <= in_comment_next;
            in_token_reg   <= in_token_next;
            tok_val_reg    <= tok_val_next;
            tok_digits_reg <= tok_digits_next;
            tok_neg_reg    <= tok_neg_next;
            tok_stop_reg   <= tok_stop_next;
            tok_ovf_reg    <= tok_ovf_next;
            magic_reg      <= magic_next;
            width_reg      <= width_next;
            height_reg     <= height_next;
            maxval_reg     <= maxval_next;
            bytes_left_reg <= bytes_left_next;
            state_reg      <= state_next;
            div_cnt_reg    <= div_cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        dvd_reg        <= dvd_next;
        rem_reg        <= rem_next;
        quo_reg        <= quo_next;
        div_last_reg   <= div_last_next;
        out_kind_reg   <= out_kind_next;
        out_sample_reg <= out_sample_next;
        out_width_reg  <= out_width_next;
        out_height_reg <= out_height_next;
        out_maxval_reg <= out_maxval_next;
        out_err_reg    <= out_err_next;
        out_last_reg   <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {3'd0, out_err_reg, out_maxval_reg, out_height_reg,
                       out_width_reg, out_sample_reg};

    a_busy_not_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> !s_tready)
        else $error("input taken while divider busy");

    a_div_result: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_DIV) && (div_cnt_reg == 4'd15)) |=>
            (m_tvalid && (m_tuser == KIND_SAMPLE)))
        else $error("divider finished without a sample word");

    a_data_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_DATA) |-> (bytes_left_reg != '0))
        else $error("sample phase with no bytes left");

    a_error_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && (out_kind_reg == KIND_ERROR)) |-> out_last_reg)
        else $error("error word without last");

endmodule

// File: bench/ppm_p6_stream_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppm_p6_stream_decoder_tb
// Feeds P6 files byte by byte, mostly well-formed headers with random spacing,
// comments, signs and pixel data, plus corrupted files and plain noise. A
// scoreboard decodes every accepted word on its own and checks each output
// word in order while both stream sides idle at random.
// ----------------------------------------------------------------------------
module ppm_p6_stream_decoder_tb;
    import ppmsd_pkg::*;

    typedef struct {
        kind_t              kind;
        logic [7:0]         sample;
        logic [DIM_W-1:0]   width;
        logic [DIM_W-1:0]   height;
        logic [MAXV_W-1:0]  maxv;
        err_t               code;
        logic               last;
    } ppm_result_t;

    function automatic logic is_space_byte(input logic [7:0] c);
        return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    class ppm_scoreboard;
        ppm_result_t        pending_results[$];
        int                 fails;
        phase_t             stage;
        logic               comment_open;
        logic               token_open;
        logic [TOK_W-1:0]   tok_value;
        logic               tok_digits;
        logic               tok_neg;
        logic               tok_stop;
        logic               tok_ovf;
        magic_t             magic_seen;
        logic [DIM_W-1:0]   width_q;
        logic [DIM_W-1:0]   height_q;
        logic [MAXV_W-1:0]  maxval_q;
        logic [BYTES_W-1:0] samples_left;

        function new();
            fails = 0;
            restart();
        endfunction

        function void clear_token();
            token_open = 1'b0;
            tok_value  = '0;
            tok_digits = 1'b0;
            tok_neg    = 1'b0;
            tok_stop   = 1'b0;
            tok_ovf    = 1'b0;
            magic_seen = MAG_NONE;
        endfunction

        function void restart();
            stage        = PH_MAGIC;
            comment_open = 1'b0;
            clear_token();
            width_q      = '0;
            height_q     = '0;
            maxval_q     = '0;
            samples_left = '0;
        endfunction

        function void push_result(kind_t k, logic [7:0] s, logic [DIM_W-1:0] w,
                                  logic [DIM_W-1:0] h, logic [MAXV_W-1:0] m,
                                  err_t e, logic l);
            ppm_result_t r;
            r.kind   = k;
            r.sample = s;
            r.width  = w;
            r.height = h;
            r.maxv   = m;
            r.code   = e;
            r.last   = l;
            pending_results.insert(pending_results.size(), r);
        endfunction

        function void take_char(logic [7:0] c, logic first);
            int v;
            if (stage == PH_MAGIC) begin
                if (first)
                    magic_seen = (c == CH_P) ? MAG_SAW_P : MAG_MISMATCH;
                else
                    magic_seen = (magic_seen == MAG_SAW_P && c == CH_6) ?
                                 MAG_SAW_P6 : MAG_MISMATCH;
                return;
            end
            if (tok_stop)
                return;
            if (c >= CH_0 && c <= CH_9) begin
                v = int'(tok_value) * 10 + int'(c - CH_0);
                // saturate at the token register's capacity
                if (v > int'(TOK_CAP)) begin
                    v = int'(TOK_CAP);
                    tok_ovf = 1'b1;
                end
                tok_value  = v[TOK_W-1:0];
                tok_digits = 1'b1;
            end else if (first && c == CH_PLUS) begin
            end else if (first && c == CH_MINUS) begin
                tok_neg = 1'b1;
            end else begin
                tok_stop = 1'b1;
            end
        endfunction

        // Returns 1 when the finished token is acceptable; code holds the error.
        function logic token_passes(output err_t code);
            int unsigned bound;
            int unsigned v;
            code = ERR_EARLY_END;
            if (stage == PH_MAGIC) begin
                if (magic_seen == MAG_SAW_P6)
                    return 1'b1;
                code = ERR_BAD_MAGIC;
                return 1'b0;
            end
            if (!tok_digits) begin
                code = ERR_NO_DIGITS;
                return 1'b0;
            end
            bound = (stage == PH_MAXVAL) ? MAX_SAMPLE_VALUE : MAX_DIM;
            v = tok_neg ? 0 : tok_value;
            if (!tok_neg && (tok_ovf || v > bound)) begin
                code = ERR_TOO_LARGE;
                return 1'b0;
            end
            if (stage == PH_WIDTH) begin
                width_q = v[DIM_W-1:0];
            end else if (stage == PH_HEIGHT) begin
                height_q = v[DIM_W-1:0];
            end else begin
                maxval_q = v[MAXV_W-1:0];
                if (width_q == 0 || height_q == 0 || maxval_q == 0) begin
                    code = ERR_ZERO;
                    return 1'b0;
                end
            end
            return 1'b1;
        endfunction

        // Decode one accepted word; returns 0 when the decoder just drops it.
        function logic decode_byte(logic [7:0] c, logic eos);
            err_t        code;
            int unsigned q;
            longint unsigned total;
            if (eos) begin
                if (stage inside {PH_MAGIC, PH_WIDTH, PH_HEIGHT, PH_MAXVAL}) begin
                    code = ERR_EARLY_END;
                    if (token_open && token_passes(code))
                        code = ERR_EARLY_END;
                    push_result(KIND_ERROR, '0, '0, '0, '0, code, 1'b1);
                end else if (stage == PH_DATA) begin
                    push_result(KIND_ERROR, '0, '0, '0, '0, ERR_EARLY_END, 1'b1);
                end
                restart();
                return 1'b1;
            end
            if (stage == PH_DONE || stage == PH_ERROR)
                return 1'b0;
            if (stage == PH_DATA) begin
                q = c;
                if (maxval_q != 16'd255 && maxval_q != 0) begin
                    q = (int'(c) * 255) / int'(maxval_q);
                    if (q > 255)
                        q = 255;
                end
                push_result(KIND_SAMPLE, q[7:0], '0, '0, '0, ERR_BAD_MAGIC,
                            samples_left == 1);
                samples_left = samples_left - 1'b1;
                if (samples_left == 0)
                    stage = PH_DONE;
                return 1'b1;
            end
            if (comment_open) begin
                if (c == CH_LF)
                    comment_open = 1'b0;
                return 1'b1;
            end
            if (!token_open) begin
                if (is_space_byte(c))
                    return 1'b1;
                if (c == CH_HASH) begin
                    comment_open = 1'b1;
                    return 1'b1;
                end
                token_open = 1'b1;
                take_char(c, 1'b1);
                return 1'b1;
            end
            if (!is_space_byte(c)) begin
                take_char(c, 1'b0);
                return 1'b1;
            end
            if (!token_passes(code)) begin
                clear_token();
                stage = PH_ERROR;
                push_result(KIND_ERROR, '0, '0, '0, '0, code, 1'b1);
                return 1'b1;
            end
            clear_token();
            case (stage)
                PH_MAGIC:  stage = PH_WIDTH;
                PH_WIDTH:  stage = PH_HEIGHT;
                PH_HEIGHT: stage = PH_MAXVAL;
                default: begin
                    total = longint'(width_q) * height_q * 3;
                    samples_left = total[BYTES_W-1:0];
                    stage = (samples_left == 0) ? PH_DONE : PH_DATA;
                    push_result(KIND_HEADER, '0, width_q, height_q, maxval_q,
                                ERR_BAD_MAGIC, 1'b0);
                end
            endcase
            return 1'b1;
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want !== got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                fails++;
            end
        endfunction

        function void check_output(logic [55:0] data, logic [KIND_W-1:0] user,
                                   logic lst);
            ppm_result_t want;
            if (pending_results.size() == 0) begin
                $error("unexpected output word: kind %0d, data %h", user, data);
                fails++;
                return;
            end
            want = pending_results.pop_front();
            compare_field("kind", want.kind, user);
            compare_field("sample", want.sample, data[7:0]);
            compare_field("image_width", want.width, data[20:8]);
            compare_field("image_height", want.height, data[33:21]);
            compare_field("max_value", want.maxv, data[49:34]);
            compare_field("error_code", want.code, data[52:50]);
            compare_field("last", want.last, lst);
        endfunction
    endclass

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata  = '0;
    logic              s_tlast  = 1'b0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [55:0]       m_tdata;
    logic [KIND_W-1:0] m_tuser;
    logic              m_tlast;

    ppm_scoreboard sb = new();
    logic [7:0]    file_q[$];
    int            send_idle_pct  = 0;
    int            recv_stall_pct = 0;
    int            parsed_words   = 0;
    int            file_idx       = 0;

    ppm_p6_stream_decoder u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #5 aclk = ~aclk;

    // Output side: check each word, then pick the next ready at random.
    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready)
                sb.check_output(m_tdata, m_tuser, m_tlast);
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic void add_byte(input logic [7:0] b);
        file_q.insert(file_q.size(), b);
    endfunction

    function automatic void put_str(string s);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i]);
    endfunction

    function automatic logic [7:0] blank_byte();
        case ($urandom_range(5))
            0: return CH_TAB;
            1: return CH_LF;
            2: return 8'd11;
            3: return 8'd12;
            4: return CH_CR;
            default: return CH_SPACE;
        endcase
    endfunction

    function automatic void put_sep();
        logic [7:0] b;
        int n;
        n = $urandom_range(1, 3);
        repeat (n) add_byte(blank_byte());
        if ($urandom_range(4) == 0) begin
            add_byte(CH_HASH);
            repeat ($urandom_range(5)) begin
                do b = 8'($urandom_range(255)); while (b == CH_LF);
                add_byte(b);
            end
            add_byte(CH_LF);
            if ($urandom_range(1) == 0)
                add_byte(blank_byte());
        end
    endfunction

    // Decimal text with optional leading zeros, plus sign and trailing junk.
    function automatic string num_text(int unsigned v);
        string s;
        s = $sformatf("%0d", v);
        if ($urandom_range(9) == 0)
            s = {"00", s};
        if ($urandom_range(7) == 0)
            s = {"+", s};
        if ($urandom_range(9) == 0) begin
            case ($urandom_range(5))
                0: s = {s, "x"};
                1: s = {s, "#"};
                2: s = {s, "-1"};
                3: s = {s, "+2"};
                4: s = {s, ".5"};
                default: s = {s, "a#b"};
            endcase
        end
        return s;
    endfunction

    function automatic int unsigned pick_dim();
        case ($urandom_range(19))
            0: return MAX_DIM;
            1: return $urandom_range(1, MAX_DIM);
            default: return $urandom_range(1, 4);
        endcase
    endfunction

    function automatic void build_random_file();
        string       tok[3];
        string       magic;
        int unsigned w, h, mv, k, pick, keep;
        longint unsigned n, count;
        logic        faulty;
        err_t        fault;
        logic [7:0]  b;
        file_q.delete();
        pick = $urandom_range(99);
        if (pick >= 88) begin
            repeat ($urandom_range(1, 16)) begin
                if ($urandom_range(1) == 0) begin
                    magic = "P6 #\n+-0123456789x";
                    add_byte(magic[$urandom_range(magic.len() - 1)]);
                end else begin
                    add_byte(8'($urandom_range(255)));
                end
            end
            return;
        end
        faulty = (pick >= 66);
        fault  = err_t'($urandom_range(4));
        w = pick_dim();
        h = pick_dim();
        case ($urandom_range(9))
            0, 1, 2: mv = 255;
            3:       mv = MAX_SAMPLE_VALUE;
            4:       mv = 1;
            5:       mv = $urandom_range(2, 20);
            6:       mv = $urandom_range(254, 256);
            default: mv = $urandom_range(2, MAX_SAMPLE_VALUE);
        endcase
        magic  = "P6";
        tok[0] = num_text(w);
        tok[1] = num_text(h);
        tok[2] = num_text(mv);
        k = $urandom_range(2);
        if (faulty) begin
            case (fault)
                ERR_BAD_MAGIC: begin
                    case ($urandom_range(7))
                        0: magic = "P5";
                        1: magic = "P";
                        2: magic = "P66";
                        3: magic = "p6";
                        4: magic = "6P";
                        5: magic = "P6#";
                        6: magic = "Q6";
                        default: magic = "PP6";
                    endcase
                end
                ERR_NO_DIGITS: begin
                    case ($urandom_range(6))
                        0: tok[k] = "x";
                        1: tok[k] = "+";
                        2: tok[k] = "-";
                        3: tok[k] = "+-3";
                        4: tok[k] = "a#";
                        5: tok[k] = "-x9";
                        default: tok[k] = "++1";
                    endcase
                end
                ERR_ZERO: begin
                    case ($urandom_range(5))
                        0: tok[k] = "0";
                        1: tok[k] = "000";
                        2: tok[k] = "-5";
                        3: tok[k] = "+0";
                        4: tok[k] = "-0";
                        default: tok[k] = "-99999999";
                    endcase
                end
                ERR_TOO_LARGE: begin
                    if ($urandom_range(3) == 0)
                        tok[k] = "4294967296123";
                    else if (k == 2)
                        tok[k] = num_text($urandom_range(MAX_SAMPLE_VALUE + 1, 131071));
                    else
                        tok[k] = num_text($urandom_range(MAX_DIM + 1, 131071));
                end
                default: ;
            endcase
        end
        if ($urandom_range(9) == 0)
            put_sep();
        put_str(magic);
        put_sep();
        put_str(tok[0]);
        put_sep();
        put_str(tok[1]);
        put_sep();
        put_str(tok[2]);
        add_byte(blank_byte());
        keep = file_q.size();
        n = longint'(w) * h * 3;
        if (faulty || n > 48) begin
            count = $urandom_range(12);
        end else begin
            count = n;
            if ($urandom_range(6) == 0)
                count = $urandom_range(n - 1);
            else if ($urandom_range(4) == 0)
                count = n + $urandom_range(1, 6);
        end
        repeat (count) begin
            b = 8'($urandom_range(255));
            add_byte(b);
        end
        // cut the header short
        if (faulty && fault == ERR_EARLY_END) begin
            keep = $urandom_range(keep - 1);
            while (file_q.size() > keep)
                void'(file_q.pop_back());
        end
    endfunction

    task automatic send_word(input logic [7:0] b, input logic eos);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eos;
        do @(posedge aclk); while (!s_tready);
        void'(sb.decode_byte(b, eos));
        parsed_words++;
    endtask

    task automatic send_file();
        case ((file_idx / 3) % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
            default: begin send_idle_pct = 28; recv_stall_pct = 28; end
        endcase
        file_idx++;
        foreach (file_q[i])
            send_word(file_q[i], 1'b0);
        send_word(8'($urandom_range(255)), 1'b1);
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // passthrough-free rescale with saturation, full image, comment-free
        file_q.delete();
        put_str("P6 1 1 7\n");
        add_byte(8'hFF);
        add_byte(8'h00);
        add_byte(8'h07);
        send_file();
        // hash inside the magic token
        file_q.delete();
        put_str("P6#\n");
        send_file();
        // token without digits, rest ignored
        file_q.delete();
        put_str("P6 1 x 7 ");
        send_file();

        while (parsed_words < 1050) begin
            build_random_file();
            send_file();
        end
        s_tvalid <= 1'b0;

        while (sb.pending_results.size() != 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (sb.fails == 0)
            $display("ppm_p6_stream_decoder: match");
        else
            $display("ppm_p6_stream_decoder: mismatch");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("ppm_p6_stream_decoder: mismatch");
        $finish;
    end

endmodule
